### src/wrp_pkg.sv
// Shared constants and types for the weighted random picker.
// Used by wrp_cell, wrp_chain and weighted_random_picker_core; depends on nothing.
package wrp_pkg;

    localparam int TABLE_SIZE  = 16;
    localparam int WEIGHT_BITS = 16;

    localparam int WEIGHT_W = 16;
    localparam int VAL_W    = 16;
    localparam int CUM_W    = 20;
    localparam int IDX_W    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int POS_W    = $clog2(TABLE_SIZE + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
        (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}}
                                  : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = PADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_RETURN_VALUES = CFG_IDX_W'(0);

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_PICK = 1'b1
    } t_mode;

    typedef struct packed {
        logic             shift;
        logic [CUM_W-1:0] cum;
        logic [VAL_W-1:0] value;
        logic             probe;
        logic [CUM_W-1:0] draw;
    } t_chain_ctl;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic [VAL_W-1:0] value;
    } t_chain_rsp;

endpackage

### src/wrp_cell.sv
// One table cell: a cumulative weight, its value and the scan probe bit.
// Depends on wrp_pkg.
module wrp_cell
    import wrp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [CUM_W-1:0] i_cum,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_probe,
    input  logic [CUM_W-1:0] i_draw,
    output logic [CUM_W-1:0] o_cum,
    output logic [VAL_W-1:0] o_value,
    output logic             o_probe,
    output logic             o_probe_pass,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_hit_value
);

    logic [CUM_W-1:0] r_cum;
    logic [VAL_W-1:0] r_value;
    logic             r_probe;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_cum   <= i_cum;
            r_value <= i_value;
        end
        if (!i_rst_n) begin
            r_probe <= 1'b0;
        end else begin
            r_probe <= i_probe;
        end
    end

    // The probe stops at the first cell whose cumulative weight exceeds the draw.
    assign o_hit        = r_probe && (i_draw < r_cum);
    assign o_probe_pass = r_probe && !o_hit;
    assign o_hit_value  = o_hit ? r_value : '0;
    assign o_cum        = r_cum;
    assign o_value      = r_value;
    assign o_probe      = r_probe;

endmodule

### src/wrp_chain.sv
// Row of TABLE_SIZE cells: loads shift in at the top end, the probe walks up from cell 0.
// Depends on wrp_pkg and wrp_cell.
module wrp_chain
    import wrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    output t_chain_rsp o_rsp
);

    logic [CUM_W-1:0] cum_q   [TABLE_SIZE];
    logic [VAL_W-1:0] value_q [TABLE_SIZE];
    logic [CUM_W-1:0] cum_in  [TABLE_SIZE];
    logic [VAL_W-1:0] value_in[TABLE_SIZE];
    logic             probe_in[TABLE_SIZE];
    logic [TABLE_SIZE-1:0] probe_q;
    logic [TABLE_SIZE-1:0] probe_pass;
    logic [TABLE_SIZE-1:0] hit;
    logic [VAL_W-1:0] hit_value[TABLE_SIZE];

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
        if (k == TABLE_SIZE - 1) begin : g_top
            assign cum_in[k]   = i_ctl.cum;
            assign value_in[k] = i_ctl.value;
        end else begin : g_mid
            assign cum_in[k]   = cum_q[k+1];
            assign value_in[k] = value_q[k+1];
        end
        if (k == 0) begin : g_first
            assign probe_in[k] = i_ctl.probe;
        end else begin : g_next
            assign probe_in[k] = probe_pass[k-1];
        end

        // Cell 0 has no lower neighbor, so its stored data is only seen by the scan.
        wrp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (i_ctl.shift),
            .i_cum        (cum_in[k]),
            .i_value      (value_in[k]),
            .i_probe      (probe_in[k]),
            .i_draw       (i_ctl.draw),
            .o_cum        (cum_q[k]),
            .o_value      (value_q[k]),
            .o_probe      (probe_q[k]),
            .o_probe_pass (probe_pass[k]),
            .o_hit        (hit[k]),
            .o_hit_value  (hit_value[k])
        );
    end

    // At most one cell holds the probe, so the hit values can simply be ORed.
    always_comb begin
        o_rsp.hit   = |hit;
        o_rsp.miss  = probe_pass[TABLE_SIZE-1];
        o_rsp.value = '0;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            o_rsp.value = o_rsp.value | hit_value[k];
        end
    end

    a_probe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(probe_q))
        else $error("more than one cell holds the scan probe");

    a_hit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("more than one cell reports a hit");

endmodule

### src/weighted_random_picker_core.sv
// Top level of the weighted random picker (roulette wheel selection).
// Depends on wrp_pkg and wrp_chain (which holds the wrp_cell row).
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  input    | in        | i_in_valid / o_in_ready | i_mode i_start_load i_weight i_entry_value i_draw
//  result   | out       | o_out_valid/i_out_ready | o_picked o_error
//  config   | in        | psel penable pwrite     | paddr pwdata -> prdata, pready tied high
//
//  A load transaction produces no result.
//  A pick that fails the table/total/draw checks returns an error without a scan.
//  A valid pick returns the entry on which the probe hits as it walks up the cell row
//  one cell per clock.
//  Synchronous active-low reset empties the table state and clears return_values.
//  A result that cannot leave because the output is stalled waits in a holding register;
//  no new transaction is taken until it has moved into the output register.
module weighted_random_picker_core
    import wrp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input transactions
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic                      i_start_load,
    input  logic [WEIGHT_W-1:0]       i_weight,
    input  logic signed [VAL_W-1:0]   i_entry_value,
    input  logic [CUM_W-1:0]          i_draw,
    // result transactions
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VAL_W-1:0]   o_picked,
    output logic                      o_error,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // Control state.
    t_state           r_state,         n_state;
    logic [POS_W-1:0] r_pos,           n_pos;
    logic [CUM_W-1:0] r_total,         n_total;
    logic             r_ready_tbl,     n_ready_tbl;
    logic [IDX_W-1:0] r_idx,           n_idx;
    logic             r_out_valid,     n_out_valid;
    logic             r_return_values, n_return_values;

    // Payload registers.
    logic [CUM_W-1:0]        r_draw,        n_draw;
    logic signed [VAL_W-1:0] r_picked,      n_picked;
    logic                    r_error,       n_error;
    logic signed [VAL_W-1:0] r_hold_picked, n_hold_picked;
    logic                    r_hold_error,  n_hold_error;

    t_chain_ctl chain_ctl;
    t_chain_rsp chain_rsp;

    logic                    in_fire;
    logic                    out_free;
    logic                    cfg_wr;
    logic                    eff_start;
    logic [POS_W-1:0]        eff_pos;
    logic [CUM_W-1:0]        eff_total;
    logic [CUM_W:0]          sum_ext;
    logic [CUM_W-1:0]        sum_sat;
    logic                    pick_ok;
    logic                    res_valid;
    logic signed [VAL_W-1:0] res_picked;
    logic                    res_error;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_picked    = r_picked;
    assign o_error     = r_error;

    // Configuration: one register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_RETURN_VALUES: prdata = {{(PDATA_W-1){1'b0}}, r_return_values};
            default:           prdata = '0;
        endcase
    end

    // Load path: a restart clears the position and total before this entry is stored.
    // The total saturates at its full-scale value instead of wrapping.
    assign eff_start = (i_mode == MODE_LOAD) && i_start_load;
    assign eff_pos   = eff_start ? '0 : r_pos;
    assign eff_total = eff_start ? '0 : r_total;
    assign sum_ext   = {1'b0, eff_total} + (CUM_W+1)'(i_weight & WEIGHT_MASK);
    assign sum_sat   = sum_ext[CUM_W] ? {CUM_W{1'b1}} : sum_ext[CUM_W-1:0];

    // A pick can only succeed on a full table with a nonzero total and a draw below it.
    // The last cell then holds the running total, so the probe always finds a hit.
    assign pick_ok = r_ready_tbl && (r_total != '0) && (i_draw < r_total);

    always_comb begin
        n_state         = r_state;
        n_pos           = r_pos;
        n_total         = r_total;
        n_ready_tbl     = r_ready_tbl;
        n_idx           = r_idx;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_return_values = r_return_values;
        n_draw          = r_draw;
        n_picked        = r_picked;
        n_error         = r_error;
        n_hold_picked   = r_hold_picked;
        n_hold_error    = r_hold_error;

        chain_ctl.shift = 1'b0;
        chain_ctl.cum   = sum_sat;
        chain_ctl.value = i_entry_value;
        chain_ctl.probe = 1'b0;
        chain_ctl.draw  = r_draw;

        res_valid  = 1'b0;
        res_picked = '0;
        res_error  = 1'b0;

        if (cfg_wr && (paddr[PADDR_W-1:2] == REG_RETURN_VALUES)) begin
            n_return_values = pwdata[0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_mode == MODE_LOAD) begin
                        if (eff_start) begin
                            n_pos       = '0;
                            n_total     = '0;
                            n_ready_tbl = 1'b0;
                        end
                        // Loads into a full table without a restart are dropped.
                        if (eff_pos < POS_W'(TABLE_SIZE)) begin
                            chain_ctl.shift = 1'b1;
                            n_total         = sum_sat;
                            n_pos           = eff_pos + POS_W'(1);
                            if (eff_pos == POS_W'(TABLE_SIZE - 1)) begin
                                n_ready_tbl = 1'b1;
                            end
                        end
                    end else if (pick_ok) begin
                        n_draw          = i_draw;
                        n_idx           = '0;
                        chain_ctl.probe = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        res_valid = 1'b1;
                        res_error = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (chain_rsp.hit) begin
                    res_valid  = 1'b1;
                    res_picked = r_return_values ? $signed(chain_rsp.value)
                                                 : $signed(VAL_W'(r_idx));
                end else if (chain_rsp.miss) begin
                    res_valid = 1'b1;
                    res_error = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_picked    = r_hold_picked;
                    n_error     = r_hold_error;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free,
        // otherwise it waits in the holding register.
        if (res_valid) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_picked    = res_picked;
                n_error     = res_error;
                n_state     = ST_IDLE;
            end else begin
                n_hold_picked = res_picked;
                n_hold_error  = res_error;
                n_state       = ST_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw        <= n_draw;
        r_picked      <= n_picked;
        r_error       <= n_error;
        r_hold_picked <= n_hold_picked;
        r_hold_error  <= n_hold_error;
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_pos           <= '0;
            r_total         <= '0;
            r_ready_tbl     <= 1'b0;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
            r_return_values <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_pos           <= n_pos;
            r_total         <= n_total;
            r_ready_tbl     <= n_ready_tbl;
            r_idx           <= n_idx;
            r_out_valid     <= n_out_valid;
            r_return_values <= n_return_values;
        end
    end

    wrp_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chain_ctl),
        .o_rsp   (chain_rsp)
    );

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error) |-> (r_picked == '0))
        else $error("error result carries a nonzero pick");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_tbl |-> (r_pos == POS_W'(TABLE_SIZE)))
        else $error("table marked ready before it was full");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(TABLE_SIZE))
        else $error("load position ran past the table");

    a_scan_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !chain_rsp.miss)
        else $error("scan ran off the table without a hit");

    a_launch_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_mode == MODE_PICK) && pick_ok) |=> (r_state == ST_SCAN))
        else $error("accepted pick did not start a scan");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_random_picker_core: directed and random load and
// pick transactions, checked against a roulette wheel predictor kept inside the bench.
// Depends on wrp_pkg and the RTL under src/.
module tb_top;
    import wrp_pkg::*;

    // The pause before a register write or the end of the run covers the longest
    // correct pick with margin.
    localparam int DRAIN_CYCLES   = 2 * TABLE_SIZE + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT   = 11;
    localparam logic [CUM_W-1:0] TOTAL_MAX = {CUM_W{1'b1}};

    typedef struct packed {
        logic signed [VAL_W-1:0] picked;
        logic                    error;
    } t_pick_result;

    // Clock, reset and every DUT input start at a known value.
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_mode       = MODE_LOAD;
    logic                    in_start_load = 1'b0;
    logic [WEIGHT_W-1:0]     in_weight     = '0;
    logic signed [VAL_W-1:0] in_entry_value = '0;
    logic [CUM_W-1:0]        in_draw       = '0;
    logic                    out_ready     = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [PADDR_W-1:0]      paddr         = '0;
    logic [PDATA_W-1:0]      pwdata        = '0;

    logic                    o_in_ready;
    logic                    o_out_valid;
    logic signed [VAL_W-1:0] o_picked;
    logic                    o_error;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // Predictor state: the cumulative weight wheel as the block should hold it.
    logic [CUM_W-1:0]        wheel_cum [TABLE_SIZE];
    logic signed [VAL_W-1:0] wheel_val [TABLE_SIZE];
    logic [CUM_W-1:0]        wheel_total   = '0;
    logic [POS_W-1:0]        fill_pos      = '0;
    logic                    wheel_full    = 1'b0;
    logic                    return_values = 1'b0;

    // Expected pick results, oldest first.
    t_pick_result pending_picks [$];

    int  mismatches   = 0;
    int  useful_items = 0;
    int  n_loads      = 0;
    int  n_picks      = 0;
    int  n_pick_errors = 0;
    int  stall_cnt    = 0;

    // Receiver control: a long hold is requested by bumping hold_requests; the receiver
    // process counts the hold out itself. steady turns random idling off on both sides.
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    logic steady        = 1'b0;

    weighted_random_picker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (in_mode),
        .i_start_load  (in_start_load),
        .i_weight      (in_weight),
        .i_entry_value (in_entry_value),
        .i_draw        (in_draw),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_picked      (o_picked),
        .o_error       (o_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mismatch bookkeeping: the first ten are described, the rest only counted.
    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch %0d: %s expected %0d got %0d",
                     $realtime, mismatches, what, want, got);
        end
    endfunction

    // Applies one accepted transaction to the predictor. Loads update the wheel; a pick
    // queues the result the block must return. Loads into a full table without a restart
    // change nothing and are not counted as useful stimulus.
    function automatic void spin_wheel(input logic mode, input logic start,
                                       input logic [WEIGHT_W-1:0] weight,
                                       input logic signed [VAL_W-1:0] value,
                                       input logic [CUM_W-1:0] draw);
        logic [CUM_W:0]   sum;
        logic [IDX_W-1:0] sel;
        logic             found;
        int               i;
        t_pick_result     res;
        if (mode == MODE_LOAD) begin
            if (start) begin
                fill_pos    = '0;
                wheel_total = '0;
                wheel_full  = 1'b0;
            end
            if (fill_pos < TABLE_SIZE) begin
                // The running total saturates instead of wrapping.
                sum = {1'b0, wheel_total} + CUM_W'(weight & WEIGHT_MASK);
                if (sum > {1'b0, TOTAL_MAX}) begin
                    sum = {1'b0, TOTAL_MAX};
                end
                wheel_total = sum[CUM_W-1:0];
                wheel_cum[fill_pos[IDX_W-1:0]] = wheel_total;
                wheel_val[fill_pos[IDX_W-1:0]] = value;
                fill_pos = fill_pos + POS_W'(1);
                if (fill_pos == TABLE_SIZE) begin
                    wheel_full = 1'b1;
                end
                n_loads++;
                useful_items++;
            end
        end else begin
            found = 1'b0;
            sel   = '0;
            // Only a full table with a nonzero total and an in-range draw can hit; the
            // first entry whose cumulative weight exceeds the draw wins, so zero-weight
            // entries are never chosen.
            if (wheel_full && wheel_total != 0 && draw < wheel_total) begin
                for (i = 0; i < TABLE_SIZE; i++) begin
                    if (!found && draw < wheel_cum[i]) begin
                        found = 1'b1;
                        sel   = IDX_W'(i);
                    end
                end
            end
            if (found) begin
                res.picked = return_values ? wheel_val[sel] : VAL_W'(sel);
                res.error  = 1'b0;
            end else begin
                res.picked = '0;
                res.error  = 1'b1;
                n_pick_errors++;
            end
            pending_picks.push_back(res);
            n_picks++;
            useful_items++;
        end
    endfunction

    // Offers one input transaction and waits until it is accepted. valid stays high
    // between back-to-back transactions; it only drops for a random idle gap.
    task automatic send_item(input logic mode, input logic start,
                             input logic [WEIGHT_W-1:0] weight,
                             input logic signed [VAL_W-1:0] value,
                             input logic [CUM_W-1:0] draw);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            gap++;
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        in_mode        <= mode;
        in_start_load  <= start;
        in_weight      <= weight;
        in_entry_value <= value;
        in_draw        <= draw;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        spin_wheel(mode, start, weight, value, draw);
    endtask

    // Loads carry a random draw and picks random load fields, so that the fields a
    // transaction does not use still see every bit toggle.
    task automatic send_load(input logic start, input logic [WEIGHT_W-1:0] weight,
                             input logic signed [VAL_W-1:0] value);
        send_item(MODE_LOAD, start, weight, value, CUM_W'($urandom));
    endtask

    task automatic send_pick(input logic [CUM_W-1:0] draw);
        send_item(MODE_PICK, 1'($urandom), WEIGHT_W'($urandom), VAL_W'($urandom), draw);
    endtask

    // Weight profiles: all zero, all maximum, tiny weights with many zeros, full range.
    function automatic logic [WEIGHT_W-1:0] weight_for(input int profile);
        if (profile == 0) begin
            return '0;
        end else if (profile == 1) begin
            return {WEIGHT_W{1'b1}};
        end else if (profile <= 4) begin
            return WEIGHT_W'($urandom_range(3));
        end
        return WEIGHT_W'($urandom);
    endfunction

    // Draws are mostly legal, with a share of entry boundaries, the exact total, the maximum
    // value and arbitrary 20-bit values that are usually out of range.
    function automatic logic [CUM_W-1:0] draw_for_wheel();
        int r;
        r = $urandom_range(99);
        if (r < 65 && wheel_total != 0) begin
            return CUM_W'($urandom_range(wheel_total - 1, 0));
        end else if (r < 82 && wheel_full) begin
            return wheel_cum[IDX_W'($urandom_range(TABLE_SIZE - 1))]
                   - CUM_W'($urandom_range(1));
        end else if (r < 90) begin
            return wheel_total;
        end else if (r < 94) begin
            return TOTAL_MAX;
        end
        return CUM_W'($urandom);
    endfunction

    // Waits until every pick has been answered, then lets the block settle, since a
    // trailing load gives no result to wait for.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes return_values over the APB port and reads it back. Only called while idle.
    task automatic program_return_values(input logic val);
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RETURN_VALUES, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The register takes the new value at this edge.
        return_values = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != PDATA_W'(return_values)) begin
            note_mismatch("return_values readback", int'(return_values), int'(rd));
        end
    endtask

    // Register access right after reset: the reset value reads back as zero, then both
    // settings are written; the directed tests run with values returned.
    task automatic test_register_access();
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {REG_RETURN_VALUES, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != '0) begin
            note_mismatch("return_values after reset", 0, int'(rd));
        end
        program_return_values(1'b0);
        program_return_values(1'b1);
    endtask

    // Directed corners: a pick with nothing loaded, a full table of zero weights, then a
    // table with extreme weights and values, a load into the full table that must be
    // ignored, and picks at the edges of the draw range.
    task automatic test_directed_tables();
        int k;
        send_pick('0);
        for (k = 0; k < TABLE_SIZE; k++) begin
            send_load(k == 0, '0, VAL_W'(k));
        end
        send_pick('0);
        send_load(1'b1, '0, 16'sd5);
        send_load(1'b0, {WEIGHT_W{1'b1}}, -16'sd32768);
        send_load(1'b0, 16'd1, 16'sd32767);
        send_load(1'b0, '0, -16'sd1);
        for (k = 4; k < TABLE_SIZE - 1; k++) begin
            send_load(1'b0, WEIGHT_W'($urandom_range(1000)), VAL_W'($urandom));
        end
        send_load(1'b0, {WEIGHT_W{1'b1}}, VAL_W'($urandom));
        send_load(1'b0, 16'd77, 16'sd77);
        send_pick('0);
        send_pick(CUM_W'(16'hFFFF));
        send_pick(wheel_total - 1'b1);
        send_pick(wheel_total);
        send_pick(TOTAL_MAX);
    endtask

    // Random traffic: mostly complete table loads followed by picks, with restarts in
    // the middle of a fill, stray loads and stray picks mixed in.
    task automatic run_random(input int quota);
        int first, kind, profile, k;
        first = useful_items;
        while (useful_items - first < quota) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                profile = $urandom_range(9);
                for (k = 0; k < TABLE_SIZE; k++) begin
                    send_load(k == 0, weight_for(profile), VAL_W'($urandom));
                end
                repeat ($urandom_range(8, 1)) send_pick(draw_for_wheel());
            end else if (kind < 88) begin
                // Restart without finishing the fill; picks must now fail.
                send_load(1'b1, WEIGHT_W'($urandom), VAL_W'($urandom));
                repeat ($urandom_range(TABLE_SIZE - 2)) begin
                    send_load(1'b0, WEIGHT_W'($urandom), VAL_W'($urandom));
                end
                send_pick(draw_for_wheel());
            end else if (kind < 94) begin
                send_load(1'b0, WEIGHT_W'($urandom), VAL_W'($urandom));
            end else begin
                send_pick(CUM_W'($urandom));
            end
        end
    endtask

    // Four random phases alternate the return mode; the third runs without any idling.
    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < 4; ph++) begin
            drain_pipeline();
            program_return_values(ph[0]);
            steady <= (ph == 2);
            run_random(200);
        end
        steady <= 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering a full
    // table and a run of picks, so the result path fills and input is stalled.
    task automatic test_backpressure();
        int k;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < TABLE_SIZE; k++) begin
            send_load(k == 0, WEIGHT_W'($urandom_range(4000)), VAL_W'($urandom));
        end
        repeat (10) send_pick(draw_for_wheel());
    endtask

    // Receiver: random ready with the idle rate of the sender, or a counted long hold.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            out_ready   <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES - 1;
        end else if (steady) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Result checker: every accepted result transaction is compared with the oldest
    // expected pick, field by field.
    always @(posedge i_clk) begin : check_results
        t_pick_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_picks.size() == 0) begin
                note_mismatch("result with no pick pending, picked", 0, int'(o_picked));
            end else begin
                want = pending_picks.pop_front();
                if (o_picked !== want.picked) begin
                    note_mismatch("picked", int'(want.picked), int'(o_picked));
                end
                if (o_error !== want.error) begin
                    note_mismatch("error", int'(want.error), int'(o_error));
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction on any port ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (psel && penable)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d picks pending",
                     $realtime, stall_cnt, pending_picks.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_tables();
        test_random_phases();
        test_backpressure();
        drain_pipeline();
        if (pending_picks.size() != 0) begin
            note_mismatch("picks left unanswered", 0, pending_picks.size());
        end
        $display("Run covered %0d table loads and %0d picks (%0d of them errors),",
                 n_loads, n_picks, n_pick_errors);
        $display("both return modes, a %0d-cycle output hold; %0d mismatches.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
